// ===== sv/u16u32_pkg.sv =====
// Shared types, constants and helper functions for the UTF-16 to UTF-32 decoder.
// No dependencies; every other file in the project refers to this package.
package u16u32_pkg;

  // Field widths and the depth of the result queue.
  localparam int unsigned UNIT_W     = 16;
  localparam int unsigned CP_W       = 21;
  localparam int unsigned FIFO_DEPTH = 2;

  // Surrogate ranges and the supplementary plane base.
  localparam logic [UNIT_W-1:0] LEAD_LO   = 16'hD800;
  localparam logic [UNIT_W-1:0] LEAD_HI   = 16'hDBFF;
  localparam logic [UNIT_W-1:0] TRAIL_LO  = 16'hDC00;
  localparam logic [UNIT_W-1:0] TRAIL_HI  = 16'hDFFF;
  localparam logic [CP_W-1:0]   SUPP_BASE = 21'h010000;

  // A count of results, from zero to two.
  typedef logic [1:0] cnt_t;

  // One result beat.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last;
  } result_t;

  // What one decoded unit pushes into the result queue.
  typedef struct packed {
    cnt_t    num;
    result_t r0;
    result_t r1;
  } push_t;

  function automatic logic is_lead(input logic [UNIT_W-1:0] unit);
    return (unit >= LEAD_LO) && (unit <= LEAD_HI);
  endfunction

  function automatic logic is_trail(input logic [UNIT_W-1:0] unit);
    return (unit >= TRAIL_LO) && (unit <= TRAIL_HI);
  endfunction

endpackage

// ===== sv/u16u32_in_reg.sv =====
// Input register stage of the UTF-16 to UTF-32 decoder.
// Holds one accepted code unit until the decode stage takes it; uses u16u32_pkg.
module u16u32_in_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [u16u32_pkg::UNIT_W-1:0]  in_code_unit,
  input  logic                           in_last_unit,
  input  logic                           take,
  output logic                           s1_valid,
  output logic [u16u32_pkg::UNIT_W-1:0]  s1_unit,
  output logic                           s1_last
);

  logic                          valid_r, valid_nxt;
  logic [u16u32_pkg::UNIT_W-1:0] unit_r;
  logic                          last_r;
  logic                          accept;

  // The stage is free when empty or when its unit leaves this cycle.
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      unit_r <= in_code_unit;
      last_r <= in_last_unit;
    end
  end

  assign s1_valid = valid_r;
  assign s1_unit  = unit_r;
  assign s1_last  = last_r;

endmodule

// ===== sv/u16u32_decode.sv =====
// Decode stage: pairs surrogates and keeps the pending leading surrogate.
// Produces up to two results per unit for the result queue; uses u16u32_pkg.
module u16u32_decode (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s1_valid,
  input  logic [u16u32_pkg::UNIT_W-1:0]  s1_unit,
  input  logic                           s1_last,
  input  u16u32_pkg::cnt_t               free,
  output logic                           take,
  output u16u32_pkg::push_t              push
);

  logic                          held_valid_r, held_valid_nxt;
  logic [u16u32_pkg::UNIT_W-1:0] held_lead_r, held_lead_nxt;
  u16u32_pkg::push_t             dec;

  // Work out the results of the unit in the input register.
  always_comb begin
    logic lead;
    logic trail;
    lead           = u16u32_pkg::is_lead(s1_unit);
    trail          = u16u32_pkg::is_trail(s1_unit);
    held_valid_nxt = held_valid_r;
    held_lead_nxt  = held_lead_r;
    dec.num        = 2'd0;
    dec.r0.cp      = {5'd0, s1_unit};
    dec.r0.last    = s1_last;
    dec.r1.cp      = {5'd0, s1_unit};
    dec.r1.last    = s1_last;
    if (held_valid_r) begin
      if (trail) begin
        // A complete pair becomes one supplementary code point.
        dec.num        = 2'd1;
        dec.r0.cp      = u16u32_pkg::SUPP_BASE + {1'b0, held_lead_r[9:0], s1_unit[9:0]};
        held_valid_nxt = 1'b0;
      end else begin
        // The held lead goes out alone, then the new unit is handled fresh.
        dec.r0.cp   = {5'd0, held_lead_r};
        dec.r0.last = 1'b0;
        if (lead && !s1_last) begin
          dec.num       = 2'd1;
          held_lead_nxt = s1_unit;
        end else begin
          dec.num        = 2'd2;
          held_valid_nxt = 1'b0;
        end
      end
    end else if (lead && !s1_last) begin
      held_valid_nxt = 1'b1;
      held_lead_nxt  = s1_unit;
    end else begin
      dec.num = 2'd1;
    end
  end

  // Take the unit only when the queue has room for all its results.
  assign take = s1_valid && (dec.num <= free);

  always_comb begin
    push     = dec;
    push.num = take ? dec.num : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else if (take) begin
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_lead_r <= held_lead_nxt;
    end
  end

endmodule

// ===== sv/u16u32_out_fifo.sv =====
// Two-entry result queue that drives the output channel.
// Accepts zero, one or two results per cycle from the decode stage; uses u16u32_pkg.
module u16u32_out_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  u16u32_pkg::push_t             push,
  output u16u32_pkg::cnt_t              free,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u16u32_pkg::CP_W-1:0]   out_code_point,
  output logic                          out_last_point
);

  u16u32_pkg::result_t mem_r [u16u32_pkg::FIFO_DEPTH];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  u16u32_pkg::cnt_t    count_r, count_nxt;
  logic                pop;

  // A beat leaves whenever one is shown and not stalled.
  assign pop  = (count_r != 2'd0) && !out_stall;
  assign free = u16u32_pkg::cnt_t'(u16u32_pkg::FIFO_DEPTH) - count_r + {1'b0, pop};

  always_comb begin
    count_nxt  = count_r + push.num - {1'b0, pop};
    wr_ptr_nxt = wr_ptr_r ^ push.num[0];
    rd_ptr_nxt = rd_ptr_r ^ pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Store the first result at the write pointer, the second after it.
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem_r[~wr_ptr_r] <= push.r1;
    end
  end

  assign out_valid      = (count_r != 2'd0);
  assign out_code_point = mem_r[rd_ptr_r].cp;
  assign out_last_point = mem_r[rd_ptr_r].last;

endmodule

// ===== sv/utf16_to_utf32_decoder.sv =====
// UTF-16 to UTF-32 decoder, top level. Input register, decode stage, result queue.
// A unit waits in the input register; its results are registered in the result queue.
// Throughput: one unit per cycle while out_stall is low; a unit that yields two results
// can hold up later units, set by the single output port of the two-entry result queue.
// Reset (rst_n, synchronous, active low) empties all stages and drops any held lead.
// Depends on u16u32_pkg, u16u32_in_reg, u16u32_decode and u16u32_out_fifo.
module utf16_to_utf32_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [u16u32_pkg::UNIT_W-1:0] in_code_unit,
  input  logic                          in_last_unit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u16u32_pkg::CP_W-1:0]   out_code_point,
  output logic                          out_last_point
);

  logic                          s1_valid;
  logic [u16u32_pkg::UNIT_W-1:0] s1_unit;
  logic                          s1_last;
  logic                          take;
  u16u32_pkg::cnt_t              free;
  u16u32_pkg::push_t             push;

  u16u32_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_code_unit (in_code_unit),
    .in_last_unit (in_last_unit),
    .take         (take),
    .s1_valid     (s1_valid),
    .s1_unit      (s1_unit),
    .s1_last      (s1_last)
  );

  u16u32_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_unit  (s1_unit),
    .s1_last  (s1_last),
    .free     (free),
    .take     (take),
    .push     (push)
  );

  u16u32_out_fifo u_out_fifo (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .free           (free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_last_point (out_last_point)
  );

endmodule

// ===== sv/u16u32_checker.sv =====
// Port-level checker for the UTF-16 to UTF-32 decoder, bound to the top level.
// Sees only the top-level ports; depends on utf16_to_utf32_decoder and u16u32_pkg.
module u16u32_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [u16u32_pkg::CP_W-1:0]   out_code_point,
  input logic                          out_last_point
);

  // A stalled result beat stays up.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_code_point) && $stable(out_last_point))
    else $error("result payload changed while stalled");

  // Decoded code points never exceed the Unicode range.
  a_cp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_code_point <= 21'h10FFFF))
    else $error("code point out of range");

  // Reset empties both sides, so no result is shown and the input is free.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty right after reset");

endmodule

bind utf16_to_utf32_decoder u16u32_checker u_chk (.*);

// ===== tb/sv/utf16_to_utf32_decoder_tb.sv =====
// Self-checking testbench for the UTF-16 to UTF-32 decoder: a directed table, then random strings.
// Predicts code points on its own or takes them from the table; compares each output beat in order.
// Depends on u16u32_pkg and the utf16_to_utf32_decoder RTL.
module utf16_to_utf32_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Row marker: the predictor supplies the expected points for this row.
  localparam int FROM_PREDICTOR = -1;
  localparam u16u32_pkg::result_t NO_POINT = '0;
  localparam int LONG_HOLD_CYCLES = 48;
  localparam int TAIL_CYCLES = 8;

  // One row of the directed stimulus.
  typedef struct {
    logic [u16u32_pkg::UNIT_W-1:0] unit;
    logic                          last;
    int                            fixed_count;
    u16u32_pkg::result_t           p0;
    u16u32_pkg::result_t           p1;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [u16u32_pkg::UNIT_W-1:0] in_code_unit = '0;
  logic                          in_last_unit = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [u16u32_pkg::CP_W-1:0]   out_code_point;
  logic                          out_last_point;

  // Predictor state: one pending leading surrogate.
  logic [u16u32_pkg::UNIT_W-1:0] pending_lead = '0;
  logic                          lead_pending = 1'b0;

  u16u32_pkg::result_t expected_points [$];
  stim_row_t           directed_rows [24];

  int fail_count = 0;
  int units_sent = 0;
  int strings_sent = 0;
  int points_checked = 0;
  int held_off_cycles = 0;
  int idle_rate = 0;
  bit long_hold_req = 1'b0;
  int hold_left = 0;

  utf16_to_utf32_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_code_unit   (in_code_unit),
    .in_last_unit   (in_last_unit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_last_point (out_last_point)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decode one code unit into zero, one or two expected code points.
  function automatic void decode_unit(input logic [u16u32_pkg::UNIT_W-1:0] unit,
                                      input logic last, output int count,
                                      output u16u32_pkg::result_t p0,
                                      output u16u32_pkg::result_t p1);
    logic [u16u32_pkg::CP_W-1:0] hi_bits;
    logic [u16u32_pkg::CP_W-1:0] lo_bits;
    count = 0;
    p0 = NO_POINT;
    p1 = NO_POINT;
    if (lead_pending) begin
      lead_pending = 1'b0;
      if (unit >= u16u32_pkg::TRAIL_LO && unit <= u16u32_pkg::TRAIL_HI) begin
        hi_bits = u16u32_pkg::CP_W'(pending_lead - u16u32_pkg::LEAD_LO);
        lo_bits = u16u32_pkg::CP_W'(unit - u16u32_pkg::TRAIL_LO);
        p0 = '{u16u32_pkg::SUPP_BASE + (hi_bits << 10) + lo_bits, last};
        count = 1;
        return;
      end
      // The lead found no partner, so it goes out alone and never ends the string.
      p0 = '{u16u32_pkg::CP_W'(pending_lead), 1'b0};
      count = 1;
    end
    if (unit >= u16u32_pkg::LEAD_LO && unit <= u16u32_pkg::LEAD_HI && !last) begin
      pending_lead = unit;
      lead_pending = 1'b1;
      return;
    end
    if (count == 0) begin
      p0 = '{u16u32_pkg::CP_W'(unit), last};
    end else begin
      p1 = '{u16u32_pkg::CP_W'(unit), last};
    end
    count++;
  endfunction

  // Offer one beat, hold it until accepted, then queue what it should produce.
  task automatic offer_unit(input logic [u16u32_pkg::UNIT_W-1:0] unit, input logic last,
                            input int fixed_count, input u16u32_pkg::result_t f0,
                            input u16u32_pkg::result_t f1);
    int                  count;
    u16u32_pkg::result_t p0;
    u16u32_pkg::result_t p1;
    if (idle_rate != 0 && $urandom_range(0, idle_rate) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_code_unit <= unit;
    in_last_unit <= last;
    do @(posedge clk); while (in_stall);
    units_sent++;
    decode_unit(unit, last, count, p0, p1);
    if (fixed_count != FROM_PREDICTOR) begin
      count = fixed_count;
      p0 = f0;
      p1 = f1;
    end
    if (count > 0) expected_points.push_back(p0);
    if (count > 1) expected_points.push_back(p1);
  endtask

  // Pause the sender until every expected point has come out.
  task automatic drain_points();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_points.size() != 0);
  endtask

  // One string of random characters; noisy strings add lone surrogates and stray flags.
  task automatic send_string(input bit clean);
    logic [u16u32_pkg::UNIT_W-1:0] units [$];
    logic                          lasts [$];
    int                            n_chars;
    int                            kind;
    bit                            run_on;
    n_chars = $urandom_range(1, 12);
    if ($urandom_range(0, 31) == 0) n_chars = $urandom_range(13, 40);
    for (int i = 0; i < n_chars; i++) begin
      kind = clean ? $urandom_range(0, 15) : $urandom_range(0, 19);
      if (kind <= 3) begin
        units.push_back(u16u32_pkg::UNIT_W'($urandom_range(0, 16'h007F)));
        lasts.push_back(1'b0);
      end else if (kind <= 9) begin
        units.push_back(u16u32_pkg::UNIT_W'($urandom_range(0, 1)
                                            ? $urandom_range(0, 16'hD7FF)
                                            : $urandom_range(16'hE000, 16'hFFFF)));
        lasts.push_back(1'b0);
      end else if (kind <= 15) begin
        units.push_back(u16u32_pkg::UNIT_W'($urandom_range(u16u32_pkg::LEAD_LO,
                                                           u16u32_pkg::LEAD_HI)));
        units.push_back(u16u32_pkg::UNIT_W'($urandom_range(u16u32_pkg::TRAIL_LO,
                                                           u16u32_pkg::TRAIL_HI)));
        lasts.push_back(1'b0);
        lasts.push_back(1'b0);
      end else if (kind == 16) begin
        units.push_back(u16u32_pkg::UNIT_W'($urandom_range(u16u32_pkg::LEAD_LO,
                                                           u16u32_pkg::LEAD_HI)));
        lasts.push_back(1'b0);
      end else if (kind == 17) begin
        units.push_back(u16u32_pkg::UNIT_W'($urandom_range(u16u32_pkg::TRAIL_LO,
                                                           u16u32_pkg::TRAIL_HI)));
        lasts.push_back(1'b0);
      end else begin
        units.push_back(u16u32_pkg::UNIT_W'($urandom_range(0, 16'hFFFF)));
        lasts.push_back(kind == 19 ? 1'($urandom_range(0, 1)) : 1'b0);
      end
    end
    // Now and then a string runs on into the next one without its end flag.
    run_on = !clean && ($urandom_range(0, 15) == 0);
    lasts[lasts.size() - 1] = !run_on;
    foreach (units[i]) offer_unit(units[i], lasts[i], FROM_PREDICTOR, NO_POINT, NO_POINT);
    strings_sent++;
  endtask

  task automatic send_strings_until(input int unit_total);
    while (units_sent < unit_total) send_string(1'b0);
  endtask

  // Receiver: random stall bursts, plus one long hold counted here on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left <= LONG_HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (idle_rate != 0 && $urandom_range(0, idle_rate) == 0) begin
      hold_left <= $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted output beat with the oldest expected point.
  always @(posedge clk) begin
    u16u32_pkg::result_t want;
    if (rst_n && in_valid && in_stall) held_off_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("unexpected beat: code_point %h, last_point %b", out_code_point, out_last_point);
        fail_count++;
      end else begin
        want = expected_points.pop_front();
        points_checked++;
        if (out_code_point !== want.cp) begin
          $error("code_point: expected %h, actual %h", want.cp, out_code_point);
          fail_count++;
        end
        if (out_last_point !== want.last) begin
          $error("last_point: expected %b, actual %b", want.last, out_last_point);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("utf16_to_utf32_decoder_tb failed");
    $finish;
  end

  initial begin
    // Directed rows: extremes, pairing, lone surrogates and a lead on the last unit.
    directed_rows = '{
      '{16'h0000, 1'b0, 1, '{21'h000000, 1'b0}, NO_POINT},
      '{16'hFFFF, 1'b1, 1, '{21'h00FFFF, 1'b1}, NO_POINT},
      '{16'hD800, 1'b0, 0, NO_POINT, NO_POINT},
      '{16'hDC00, 1'b0, 1, '{21'h010000, 1'b0}, NO_POINT},
      '{16'hDBFF, 1'b0, 0, NO_POINT, NO_POINT},
      '{16'hDFFF, 1'b1, 1, '{21'h10FFFF, 1'b1}, NO_POINT},
      '{16'hDC00, 1'b0, 1, '{21'h00DC00, 1'b0}, NO_POINT},
      '{16'hDFFF, 1'b1, 1, '{21'h00DFFF, 1'b1}, NO_POINT},
      '{16'hDBFF, 1'b1, 1, '{21'h00DBFF, 1'b1}, NO_POINT},
      '{16'hD800, 1'b0, 0, NO_POINT, NO_POINT},
      '{16'h0041, 1'b0, 2, '{21'h00D800, 1'b0}, '{21'h000041, 1'b0}},
      '{16'hD83D, 1'b0, FROM_PREDICTOR, NO_POINT, NO_POINT},
      '{16'hD800, 1'b0, FROM_PREDICTOR, NO_POINT, NO_POINT},
      '{16'hDBFF, 1'b1, 2, '{21'h00D800, 1'b0}, '{21'h00DBFF, 1'b1}},
      '{16'hD801, 1'b0, 0, NO_POINT, NO_POINT},
      '{16'hE000, 1'b1, 2, '{21'h00D801, 1'b0}, '{21'h00E000, 1'b1}},
      '{16'hD83D, 1'b0, FROM_PREDICTOR, NO_POINT, NO_POINT},
      '{16'hDE00, 1'b1, FROM_PREDICTOR, NO_POINT, NO_POINT},
      '{16'h7FFF, 1'b0, FROM_PREDICTOR, NO_POINT, NO_POINT},
      '{16'h8000, 1'b1, FROM_PREDICTOR, NO_POINT, NO_POINT},
      '{16'hD7FF, 1'b0, FROM_PREDICTOR, NO_POINT, NO_POINT},
      '{16'hFFFD, 1'b1, FROM_PREDICTOR, NO_POINT, NO_POINT},
      '{16'hAAAA, 1'b0, FROM_PREDICTOR, NO_POINT, NO_POINT},
      '{16'h5555, 1'b1, FROM_PREDICTOR, NO_POINT, NO_POINT}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_unit(directed_rows[i].unit, directed_rows[i].last, directed_rows[i].fixed_count,
                 directed_rows[i].p0, directed_rows[i].p1);
    end
    drain_points();

    // Random strings with bursty idling on both sides.
    idle_rate = 4;
    send_strings_until(400);

    // Long receiver hold while the sender keeps offering, so the input backs up.
    idle_rate = 0;
    long_hold_req = 1'b1;
    send_strings_until(520);

    idle_rate = 12;
    send_strings_until(800);
    drain_points();

    idle_rate = 1;
    send_strings_until(1150);

    // Final stretch runs at full rate with no idling and ends on a clean string.
    idle_rate = 0;
    send_strings_until(1390);
    send_string(1'b1);

    in_valid <= 1'b0;
    do @(posedge clk); while (expected_points.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d code units in %0d strings and checked %0d code points.",
             units_sent, strings_sent, points_checked);
    $display("The input was held off on %0d cycles.", held_off_cycles);
    if (fail_count == 0) begin
      $display("utf16_to_utf32_decoder_tb passed");
    end else begin
      $display("utf16_to_utf32_decoder_tb failed");
    end
    $finish;
  end

endmodule
